// ===== rtl/tosm_pkg.sv =====
// tosm_pkg: shared types and codes of the trading order state manager
// used by tosm_front, tosm_back and trading_order_state_manager; no dependencies
`default_nettype none

package tosm_pkg;

  // input opcode
  localparam logic OP_RESPONSE = 1'b0;
  localparam logic OP_MOVE     = 1'b1;

  // exchange response types that change an entry
  localparam logic [2:0] RSP_ACCEPTED = 3'd0;
  localparam logic [2:0] RSP_CANCELED = 3'd1;
  localparam logic [2:0] RSP_FILLED   = 3'd2;

  // outgoing request kind
  localparam logic REQ_NEW    = 1'b0;
  localparam logic REQ_CANCEL = 1'b1;

  // sides
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef enum logic [2:0] {
    ES_INVALID        = 3'd0,
    ES_PENDING_NEW    = 3'd1,
    ES_LIVE           = 3'd2,
    ES_PENDING_CANCEL = 3'd3,
    ES_DEAD           = 3'd4
  } entry_state_e;

  typedef enum logic [1:0] {
    CMD_ACCEPT = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_FILL   = 2'd2,
    CMD_MOVE   = 2'd3
  } cmd_kind_e;

  typedef enum logic {
    BK_FIRST  = 1'b0,
    BK_SECOND = 1'b1
  } back_state_e;

  // classified command handed from front to back
  typedef struct packed {
    cmd_kind_e          kind;
    logic [2:0]         ticker;
    logic               side;
    logic [31:0]        qty;        // exec qty of a fill, clip of a move
    logic signed [31:0] bid_px;
    logic               bid_valid;
    logic               bid_risk_ok;
    logic signed [31:0] ask_px;
    logic               ask_valid;
    logic               ask_risk_ok;
  } cmd_t;

  // back end status seen by the top level
  typedef struct packed {
    logic step;   // back end works on the queue head this cycle
    logic pop;    // queue head retires
    logic emit;   // a request is loaded into the output register
  } back_status_t;

endpackage

`default_nettype wire

// ===== rtl/trading_order_state_manager.sv =====
// trading_order_state_manager: top level of the order entry state manager
// instantiates tosm_front and tosm_back, uses tosm_pkg
`default_nettype none

// Keeps one order entry (state, order id, price, quantity) per ticker and side.
// Exchange responses (accepted, canceled, filled) update an entry and send nothing;
// a move item visits the buy entry then the sell entry of its ticker and sends a
// cancel for a live order whose price is no longer wanted, or a new order for a
// dead or invalid entry with a valid price and a risk pass, numbered from a
// counter that starts at 1. Up to two requests per move, buy first, last_o marks
// the final one. Items go into a two-entry command queue, so the input stays open
// until it is full. The back end retires a response or a move in a single step, or
// a move in a buy step then a sell step when both sides send a request; each step
// waits for the output register, so the sustained rate is set by that register and
// the per-side sequencer: at most one request per cycle. Items for tickers at or
// above NUM_TICKERS and inert response codes are taken and dropped. The entry table
// is in flip-flops cleared by reset, so no clearing pass is needed. The user must
// write client_id over the cfg channel while idle; the block does not enforce it.
module trading_order_state_manager import tosm_pkg::*; #(
  parameter int NUM_TICKERS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write: client id
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        cfg_data_i,
  // input items
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               opcode_i,
  input  wire logic [2:0]         ticker_i,
  input  wire logic [2:0]         response_type_i,
  input  wire logic               response_side_i,
  input  wire logic [31:0]        exec_qty_i,
  input  wire logic signed [31:0] bid_px_i,
  input  wire logic               bid_valid_i,
  input  wire logic signed [31:0] ask_px_i,
  input  wire logic               ask_valid_i,
  input  wire logic [31:0]        clip_i,
  input  wire logic               bid_risk_ok_i,
  input  wire logic               ask_risk_ok_i,
  // outgoing requests
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    request_kind_o,
  output logic [15:0]             request_client_o,
  output logic [2:0]              request_ticker_o,
  output logic [31:0]             request_order_id_o,
  output logic                    request_side_o,
  output logic signed [31:0]      request_price_o,
  output logic [31:0]             request_qty_o,
  output logic                    last_o
);

  logic [15:0]  client_id_q;
  logic         head_valid;
  cmd_t         head;
  back_status_t bk_status;

  // client id register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      client_id_q <= 16'd0;
    end else if (cfg_valid_i) begin
      client_id_q <= cfg_data_i;
    end
  end

  // front end: classify and queue
  tosm_front #(
    .NUM_TICKERS (NUM_TICKERS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .ticker_i        (ticker_i),
    .response_type_i (response_type_i),
    .response_side_i (response_side_i),
    .exec_qty_i      (exec_qty_i),
    .bid_px_i        (bid_px_i),
    .bid_valid_i     (bid_valid_i),
    .ask_px_i        (ask_px_i),
    .ask_valid_i     (ask_valid_i),
    .clip_i          (clip_i),
    .bid_risk_ok_i   (bid_risk_ok_i),
    .ask_risk_ok_i   (ask_risk_ok_i),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .pop_i           (bk_status.pop)
  );

  // back end: entry table, side sequencer, output register
  tosm_back #(
    .NUM_TICKERS (NUM_TICKERS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_valid_i       (head_valid),
    .head_i             (head),
    .status_o           (bk_status),
    .client_id_i        (client_id_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .request_kind_o     (request_kind_o),
    .request_client_o   (request_client_o),
    .request_ticker_o   (request_ticker_o),
    .request_order_id_o (request_order_id_o),
    .request_side_o     (request_side_o),
    .request_price_o    (request_price_o),
    .request_qty_o      (request_qty_o),
    .last_o             (last_o)
  );

  // the queue only retires a command that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.pop |-> head_valid)
    else $error("command retired from empty queue");

  // a full queue cannot look empty to the back end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> head_valid)
    else $error("input stalled with no queued command");

  // a request is loaded only when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.emit |-> (!out_valid_o || out_ready_i))
    else $error("request overwrote a pending transfer");

  // every new request comes from a queued command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(head_valid))
    else $error("request appeared without a command");

endmodule

`default_nettype wire

// ===== rtl/tosm_front.sv =====
// tosm_front: accepts input items, drops the ones with no effect and queues commands
// depends on tosm_pkg
`default_nettype none

module tosm_front import tosm_pkg::*; #(
  parameter int NUM_TICKERS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               opcode_i,
  input  wire logic [2:0]         ticker_i,
  input  wire logic [2:0]         response_type_i,
  input  wire logic               response_side_i,
  input  wire logic [31:0]        exec_qty_i,
  input  wire logic signed [31:0] bid_px_i,
  input  wire logic               bid_valid_i,
  input  wire logic signed [31:0] ask_px_i,
  input  wire logic               ask_valid_i,
  input  wire logic [31:0]        clip_i,
  input  wire logic               bid_risk_ok_i,
  input  wire logic               ask_risk_ok_i,
  output logic                    head_valid_o,
  output cmd_t                    head_o,
  input  wire logic               pop_i
);

  localparam int QDepth = 2;

  cmd_t       fifo_q [QDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  cmd_t cmd;
  logic in_range;
  logic keep;
  logic push;

  always_comb begin
    cmd             = '0;
    cmd.ticker      = ticker_i;
    cmd.side        = response_side_i;
    cmd.qty         = (opcode_i == OP_MOVE) ? clip_i : exec_qty_i;
    cmd.bid_px      = bid_px_i;
    cmd.bid_valid   = bid_valid_i;
    cmd.bid_risk_ok = bid_risk_ok_i;
    cmd.ask_px      = ask_px_i;
    cmd.ask_valid   = ask_valid_i;
    cmd.ask_risk_ok = ask_risk_ok_i;
    if (opcode_i == OP_MOVE) begin
      cmd.kind = CMD_MOVE;
    end else if (response_type_i == RSP_ACCEPTED) begin
      cmd.kind = CMD_ACCEPT;
    end else if (response_type_i == RSP_CANCELED) begin
      cmd.kind = CMD_CANCEL;
    end else begin
      cmd.kind = CMD_FILL;
    end
  end

  // unknown tickers and inert response codes never reach the back end
  assign in_range = (32'(ticker_i) < 32'(NUM_TICKERS));
  assign keep = in_range && ((opcode_i == OP_MOVE) || (response_type_i == RSP_ACCEPTED) ||
                             (response_type_i == RSP_CANCELED) ||
                             (response_type_i == RSP_FILLED));

  assign in_ready_o   = (count_q != 2'(QDepth));
  assign push         = in_valid_i && in_ready_o && keep;
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tosm_back.sv =====
// tosm_back: order entry table, per-side sequencer and request output register
// depends on tosm_pkg
`default_nettype none

module tosm_back import tosm_pkg::*; #(
  parameter int NUM_TICKERS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_valid_i,
  input  wire cmd_t               head_i,
  output back_status_t            status_o,
  input  wire logic [15:0]        client_id_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    request_kind_o,
  output logic [15:0]             request_client_o,
  output logic [2:0]              request_ticker_o,
  output logic [31:0]             request_order_id_o,
  output logic                    request_side_o,
  output logic signed [31:0]      request_price_o,
  output logic [31:0]             request_qty_o,
  output logic                    last_o
);

  // only tickers that fit the 3-bit field can ever be stored
  localparam int NumRows = (NUM_TICKERS < 8) ? NUM_TICKERS : 8;
  localparam int RowW    = (NumRows > 1) ? $clog2(NumRows) : 1;

  entry_state_e       st_q    [NumRows][2];
  logic [31:0]        id_q    [NumRows][2];
  logic signed [31:0] price_q [NumRows][2];
  logic [31:0]        qty_q   [NumRows][2];
  logic [31:0]        next_id_q;

  back_state_e state_q, state_d;

  logic               out_valid_q;
  logic               kind_q;
  logic [15:0]        client_q;
  logic [2:0]         ticker_q;
  logic [31:0]        order_id_q;
  logic               side_q;
  logic signed [31:0] price_out_q;
  logic [31:0]        qty_out_q;
  logic               last_q;

  logic [RowW-1:0]    row;
  logic               is_move;
  logic               out_free;
  logic               step;
  logic [1:0]         want_cancel;
  logic [1:0]         want_new;
  logic [1:0]         want_req;
  logic               eff_side;
  logic               done;
  logic               emit;
  logic               emit_last;

  // entry update controls
  logic               wr_side;
  logic               st_we;
  entry_state_e       st_wd;
  logic               order_we;
  logic               qty_we;
  logic [31:0]        qty_wd;
  logic [31:0]        fill_qty;

  assign row      = head_i.ticker[RowW-1:0];
  assign is_move  = (head_i.kind == CMD_MOVE);
  assign out_free = !out_valid_q || out_ready_i;
  assign step     = head_valid_i && out_free;

  // per-side decision from the stored entry
  always_comb begin
    logic               valid_s;
    logic               risk_s;
    logic signed [31:0] price_s;
    entry_state_e       st_s;
    for (int s = 0; s < 2; s++) begin
      valid_s        = (s == 0) ? head_i.bid_valid : head_i.ask_valid;
      risk_s         = (s == 0) ? head_i.bid_risk_ok : head_i.ask_risk_ok;
      price_s        = (s == 0) ? head_i.bid_px : head_i.ask_px;
      st_s           = st_q[row][s];
      want_cancel[s] = (st_s == ES_LIVE) && (!valid_s || (price_q[row][s] != price_s));
      want_new[s]    = ((st_s == ES_INVALID) || (st_s == ES_DEAD)) && valid_s && risk_s;
      want_req[s]    = want_cancel[s] || want_new[s];
    end
  end

  // sell side is handled at once when the buy side has nothing to send
  assign eff_side  = (state_q == BK_SECOND) || !want_req[0];
  assign emit      = step && is_move && want_req[eff_side];
  assign emit_last = eff_side || !want_req[1];
  assign done      = step && (!is_move || emit_last);

  always_comb begin
    state_d = state_q;
    if (done) begin
      state_d = BK_FIRST;
    end else if (step) begin
      state_d = BK_SECOND;
    end
  end

  always_comb begin
    status_o.step = step;
    status_o.pop  = done;
    status_o.emit = emit;
  end

  assign fill_qty = (head_i.qty >= qty_q[row][head_i.side]) ?
                    32'd0 : (qty_q[row][head_i.side] - head_i.qty);

  always_comb begin
    wr_side  = is_move ? eff_side : head_i.side;
    st_we    = 1'b0;
    st_wd    = ES_INVALID;
    order_we = 1'b0;
    qty_we   = 1'b0;
    qty_wd   = fill_qty;
    if (step) begin
      unique case (head_i.kind)
        CMD_ACCEPT: begin
          st_we = 1'b1;
          st_wd = ES_LIVE;
        end
        CMD_CANCEL: begin
          st_we = 1'b1;
          st_wd = ES_DEAD;
        end
        CMD_FILL: begin
          qty_we = 1'b1;
          st_we  = (fill_qty == 32'd0);
          st_wd  = ES_DEAD;
        end
        CMD_MOVE: begin
          st_we    = emit;
          st_wd    = want_new[eff_side] ? ES_PENDING_NEW : ES_PENDING_CANCEL;
          order_we = emit && want_new[eff_side];
        end
        default: begin
          st_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) begin
        for (int s = 0; s < 2; s++) begin
          st_q[r][s]    <= ES_INVALID;
          id_q[r][s]    <= '0;
          price_q[r][s] <= '0;
          qty_q[r][s]   <= '0;
        end
      end
      next_id_q <= 32'd1;
      state_q   <= BK_FIRST;
    end else begin
      state_q <= state_d;
      if (st_we) begin
        st_q[row][wr_side] <= st_wd;
      end
      if (qty_we) begin
        qty_q[row][wr_side] <= qty_wd;
      end
      if (order_we) begin
        id_q[row][wr_side]    <= next_id_q;
        price_q[row][wr_side] <= eff_side ? head_i.ask_px : head_i.bid_px;
        qty_q[row][wr_side]   <= head_i.qty;
        next_id_q             <= next_id_q + 32'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q     <= want_cancel[eff_side] ? REQ_CANCEL : REQ_NEW;
      client_q   <= client_id_i;
      ticker_q   <= head_i.ticker;
      side_q     <= eff_side;
      last_q     <= emit_last;
      if (want_cancel[eff_side]) begin
        order_id_q  <= id_q[row][eff_side];
        price_out_q <= price_q[row][eff_side];
        qty_out_q   <= qty_q[row][eff_side];
      end else begin
        order_id_q  <= next_id_q;
        price_out_q <= eff_side ? head_i.ask_px : head_i.bid_px;
        qty_out_q   <= head_i.qty;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign request_kind_o     = kind_q;
  assign request_client_o   = client_q;
  assign request_ticker_o   = ticker_q;
  assign request_order_id_o = order_id_q;
  assign request_side_o     = side_q;
  assign request_price_o    = price_out_q;
  assign request_qty_o      = qty_out_q;
  assign last_o             = last_q;

endmodule

`default_nettype wire
